>>> rtl/ultrasonic_tank_level_averager_unit_assert.svh
// assertion macros shared by the tank level averager rtl
`ifndef ULTRASONIC_TANK_LEVEL_AVERAGER_UNIT_ASSERT_SVH
`define ULTRASONIC_TANK_LEVEL_AVERAGER_UNIT_ASSERT_SVH

// same-cycle implication, checked after reset
`define UTLA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utla assertion failed");

// next-cycle implication, checked after reset
`define UTLA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utla assertion failed");

`endif

>>> rtl/utla_pkg.sv
// shared types, constants and codes of the tank level averager
package utla_pkg;

  // echo to distance scale, unsigned q16
  localparam logic [16:0] HALF_SPEED_Q16 = 17'd111411;
  localparam logic [6:0]  MAX_READINGS   = 7'd64;
  localparam logic [15:0] PCT_SCALE      = 16'd1000;

  // widths
  localparam int ECHO_W   = 16;
  localparam int PROD_W   = 33;
  localparam int DIST_W   = 17;
  localparam int SUM_W    = 22;
  localparam int CNT_W    = 7;
  localparam int DIV_W    = 26;
  localparam int DIVR_W   = 16;
  localparam int DIV_CW   = 5;
  localparam int MUL_CW   = 4;
  localparam int LVL_W    = 24;
  localparam int OUT_W    = 56;

  // configuration register indexes
  localparam logic [2:0] REG_READINGS  = 3'd0;
  localparam logic [2:0] REG_MAX_DIST  = 3'd1;
  localparam logic [2:0] REG_TANK_H    = 3'd2;
  localparam logic [2:0] REG_OFFSET    = 3'd3;
  localparam logic [2:0] REG_TH_HIGH   = 3'd4;
  localparam logic [2:0] REG_TH_MEDIUM = 3'd5;
  localparam logic [2:0] REG_TH_LOW    = 3'd6;
  localparam logic [2:0] REG_TH_CRIT   = 3'd7;

  // level status codes
  localparam logic [2:0] LVL_EMPTY    = 3'd0;
  localparam logic [2:0] LVL_CRITICAL = 3'd1;
  localparam logic [2:0] LVL_LOW      = 3'd2;
  localparam logic [2:0] LVL_MEDIUM   = 3'd3;
  localparam logic [2:0] LVL_HIGH     = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_AVG_GO,
    S_AVG_WAIT,
    S_LEVEL,
    S_PCT_GO,
    S_PCT_WAIT,
    S_BAR_GO,
    S_BAR_WAIT,
    S_EMIT
  } utla_state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/utla_serial_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module utla_serial_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [utla_pkg::DIV_W-1:0]  dividend,
  input  logic [utla_pkg::DIVR_W-1:0] divisor,
  output logic [utla_pkg::DIV_W-1:0]  quotient,
  output utla_pkg::div_status_t       status
);
  import utla_pkg::*;

  localparam logic [DIV_CW-1:0] LAST_STEP = DIV_CW'(DIV_W - 1);

  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] dvs_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_r, dvd_r[DIV_W-1]};
    diff  = trial - {1'b0, dvs_r};
    if (!diff[DIVR_W]) begin
      rem_nxt = diff[DIVR_W-1:0];
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DIVR_W-1:0];
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient    = dvd_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

>>> rtl/ultrasonic_tank_level_averager_unit.sv
// ultrasonic tank level averager: echo scaling, batch averaging and fill outputs
// a reading runs a bit-serial multiply of the echo before in_tready returns for the next
// a batch-closing reading reaches out_tvalid, and in_tready returns, after three passes
// of the shared bit-serial divider (average, percent, bar) and a free output register;
// zero tank height skips the percent pass, no valid reading skips two (average, percent)
// synchronous active-low reset restores default registers and clears the sequencer, batch and held state and out_tvalid
module ultrasonic_tank_level_averager_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // echo_width_us[15:0]
  input  logic [15:0]                in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // distance[15:0], liquid_level[31:16], fill_percent[41:32],
  // level_status[44:42], bar_height[51:45], zero padding[55:52]
  output logic [utla_pkg::OUT_W-1:0] out_tdata,
  // sensor_error[0]
  output logic                       out_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_wr_en,
  input  logic [2:0]                 cfg_index,
  input  logic [15:0]                cfg_data
);
  import utla_pkg::*;

  localparam logic [MUL_CW-1:0] MUL_LAST = MUL_CW'(ECHO_W - 1);

  // configuration registers
  logic [6:0]  readings_r;
  logic [15:0] max_dist_r;
  logic [15:0] tank_h_r;
  logic [15:0] offset_r;
  logic [9:0]  th_high_r;
  logic [9:0]  th_medium_r;
  logic [9:0]  th_low_r;
  logic [9:0]  th_crit_r;

  // sequencer and batch state
  utla_state_t       state_r, state_nxt;
  logic [ECHO_W-1:0] echo_r;
  logic [PROD_W-1:0] acc_r;
  logic [MUL_CW-1:0] mul_cnt_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  valid_cnt_r, valid_cnt_nxt;
  logic [CNT_W-1:0]  read_cnt_r, read_cnt_nxt;
  logic [15:0]       held_level_r;
  logic [9:0]        held_pct_r;
  logic [SUM_W-1:0]  dist_r;
  logic              err_r;
  logic [6:0]        bar_r;

  // output register
  logic              out_valid_r;
  logic [15:0]       out_dist_r;
  logic [15:0]       out_level_r;
  logic [9:0]        out_pct_r;
  logic [2:0]        out_status_r;
  logic [6:0]        out_bar_r;
  logic              out_err_r;

  // combinational helpers
  logic [DIST_W-1:0] dist_now;
  logic              reading_ok;
  logic [CNT_W-1:0]  batch_len;
  logic              batch_close;
  logic [LVL_W-1:0]  level_raw;
  logic [15:0]       level_clamp;
  logic [2:0]        status_now;
  logic              out_free;
  logic              in_ready;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIVR_W-1:0] div_divisor;
  logic [DIV_W-1:0]  div_quot;
  div_status_t       div_st;
  logic              div_wait;
  logic              emit_go;

  // shared divider
  utla_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .status   (div_st)
  );

  // reading check and batch bookkeeping
  always_comb begin
    dist_now   = acc_r[PROD_W-1:ECHO_W];
    reading_ok = (dist_now != '0) && (dist_now <= {1'b0, max_dist_r});
    if (readings_r == '0) begin
      batch_len = 7'd1;
    end else if (readings_r > MAX_READINGS) begin
      batch_len = MAX_READINGS;
    end else begin
      batch_len = readings_r;
    end
    if (reading_ok) begin
      sum_nxt       = sum_r + {{(SUM_W-DIST_W){1'b0}}, dist_now};
      valid_cnt_nxt = valid_cnt_r + 1'b1;
    end else begin
      sum_nxt       = sum_r;
      valid_cnt_nxt = valid_cnt_r;
    end
    read_cnt_nxt = read_cnt_r + 1'b1;
    batch_close  = (read_cnt_nxt >= batch_len);
  end

  // level from averaged distance, clamped to zero and to the tank height
  always_comb begin
    level_raw = {8'd0, tank_h_r} + {8'd0, offset_r} - {2'd0, dist_r};
    if (level_raw[LVL_W-1]) begin
      level_clamp = '0;
    end else if (level_raw > {8'd0, tank_h_r}) begin
      level_clamp = tank_h_r;
    end else begin
      level_clamp = level_raw[15:0];
    end
  end

  // five-way status of the held percentage
  always_comb begin
    if (held_pct_r >= th_high_r) begin
      status_now = LVL_HIGH;
    end else if (held_pct_r >= th_medium_r) begin
      status_now = LVL_MEDIUM;
    end else if (held_pct_r >= th_low_r) begin
      status_now = LVL_LOW;
    end else if (held_pct_r >= th_crit_r) begin
      status_now = LVL_CRITICAL;
    end else begin
      status_now = LVL_EMPTY;
    end
  end

  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mul_cnt_r == MUL_LAST) state_nxt = S_ACC;
      end
      S_ACC: begin
        if (!batch_close) begin
          state_nxt = S_IDLE;
        end else if (valid_cnt_nxt == '0) begin
          state_nxt = S_BAR_GO;
        end else begin
          state_nxt = S_AVG_GO;
        end
      end
      S_AVG_GO:   state_nxt = S_AVG_WAIT;
      S_AVG_WAIT: begin
        if (div_st.done) state_nxt = S_LEVEL;
      end
      S_LEVEL: begin
        state_nxt = (tank_h_r == '0) ? S_BAR_GO : S_PCT_GO;
      end
      S_PCT_GO:   state_nxt = S_PCT_WAIT;
      S_PCT_WAIT: begin
        if (div_st.done) state_nxt = S_BAR_GO;
      end
      S_BAR_GO:   state_nxt = S_BAR_WAIT;
      S_BAR_WAIT: begin
        if (div_st.done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs and divider operands
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = PCT_SCALE;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_AVG_GO: begin
        div_start    = 1'b1;
        div_dividend = {{(DIV_W-SUM_W){1'b0}}, sum_r};
        div_divisor  = {{(DIVR_W-CNT_W){1'b0}}, valid_cnt_r};
      end
      S_PCT_GO: begin
        div_start    = 1'b1;
        div_dividend = {held_level_r, 10'd0} - {6'd0, held_level_r, 4'd0}
                     - {7'd0, held_level_r, 3'd0};
        div_divisor  = tank_h_r;
      end
      S_BAR_GO: begin
        div_start    = 1'b1;
        div_dividend = {{(DIV_W-17){1'b0}},
                        ({1'b0, held_pct_r, 6'd0} + {2'd0, held_pct_r, 5'd0}
                       + {5'd0, held_pct_r, 2'd0} + {6'd0, held_pct_r, 1'b0})};
        div_divisor  = PCT_SCALE;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_tready = in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      readings_r  <= 7'd10;
      max_dist_r  <= 16'd40000;
      tank_h_r    <= 16'd10000;
      offset_r    <= 16'd2000;
      th_high_r   <= 10'd800;
      th_medium_r <= 10'd500;
      th_low_r    <= 10'd250;
      th_crit_r   <= 10'd100;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_READINGS:  readings_r  <= cfg_data[6:0];
        REG_MAX_DIST:  max_dist_r  <= cfg_data;
        REG_TANK_H:    tank_h_r    <= cfg_data;
        REG_OFFSET:    offset_r    <= cfg_data;
        REG_TH_HIGH:   th_high_r   <= cfg_data[9:0];
        REG_TH_MEDIUM: th_medium_r <= cfg_data[9:0];
        REG_TH_LOW:    th_low_r    <= cfg_data[9:0];
        REG_TH_CRIT:   th_crit_r   <= cfg_data[9:0];
        default:       readings_r  <= readings_r;
      endcase
    end
  end

  // state, batch accumulators and held results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sum_r        <= '0;
      valid_cnt_r  <= '0;
      read_cnt_r   <= '0;
      held_level_r <= '0;
      held_pct_r   <= '0;
      err_r        <= 1'b0;
      mul_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          mul_cnt_r <= '0;
        end
        S_MUL: begin
          mul_cnt_r <= mul_cnt_r + 1'b1;
        end
        S_ACC: begin
          sum_r       <= sum_nxt;
          valid_cnt_r <= valid_cnt_nxt;
          read_cnt_r  <= read_cnt_nxt;
          err_r       <= (valid_cnt_nxt == '0);
        end
        S_LEVEL: begin
          held_level_r <= level_clamp;
          if (tank_h_r == '0) held_pct_r <= '0;
        end
        S_PCT_WAIT: begin
          if (div_st.done) held_pct_r <= div_quot[9:0];
        end
        S_EMIT: begin
          if (out_free) begin
            sum_r       <= '0;
            valid_cnt_r <= '0;
            read_cnt_r  <= '0;
          end
        end
        default: begin
          err_r <= err_r;
        end
      endcase
    end
  end

  // serial multiply, one echo bit per cycle from the top, and divider captures
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      echo_r <= in_tdata;
      acc_r  <= '0;
    end else if (state_r == S_MUL) begin
      acc_r  <= {acc_r[PROD_W-2:0], 1'b0}
              + (echo_r[ECHO_W-1] ? {{(PROD_W-17){1'b0}}, HALF_SPEED_Q16} : '0);
      echo_r <= {echo_r[ECHO_W-2:0], 1'b0};
    end
    if (state_r == S_AVG_WAIT && div_st.done) dist_r <= div_quot[SUM_W-1:0];
    if (state_r == S_BAR_WAIT && div_st.done) bar_r <= div_quot[6:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_err_r    <= err_r;
      out_dist_r   <= err_r ? 16'd0 : dist_r[15:0];
      out_level_r  <= held_level_r;
      out_pct_r    <= held_pct_r;
      out_status_r <= status_now;
      out_bar_r    <= bar_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_err_r;
  assign out_tdata  = {4'd0, out_bar_r, out_status_r, out_pct_r, out_level_r, out_dist_r};

  // checks
  assign div_wait = (state_r == S_AVG_WAIT) || (state_r == S_PCT_WAIT)
                 || (state_r == S_BAR_WAIT);
  assign emit_go  = (state_r == S_EMIT) && out_free;

  `include "ultrasonic_tank_level_averager_unit_assert.svh"

  `UTLA_ASSERT_IMP(a_div_done_in_wait, div_st.done, div_wait)
  `UTLA_ASSERT_IMP(a_pct_in_range, 1'b1, held_pct_r <= PCT_SCALE[9:0])
  `UTLA_ASSERT_IMP(a_batch_bounded, 1'b1, read_cnt_r <= MAX_READINGS)
  `UTLA_ASSERT_NXT(a_accept_starts_mul, in_tvalid && in_tready, state_r == S_MUL)
  `UTLA_ASSERT_NXT(a_emit_loads_out, emit_go, out_valid_r && (state_r == S_IDLE))

endmodule
